// ===== hw/rtl/bbc_pkg.sv =====
// Shared constants, types and the LFSR helper function of the block buffer cache lookup.
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

  // Field widths of the stream beats.
  localparam int unsigned BlockW     = 10;
  localparam int unsigned LimitW     = 11;
  localparam int unsigned SlotFieldW = 7;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 24;

  // Reset value of the block limit register.
  localparam logic [LimitW-1:0] LimitReset = 11'd1000;

  // Default directory size.
  localparam int unsigned Slots = 128;

  // Victim selection LFSR (Galois form).
  localparam int unsigned        LfsrW    = 16;
  localparam logic [LfsrW-1:0]   LfsrSeed = 16'hACE1;
  localparam logic [LfsrW-1:0]   LfsrMask = 16'hB400;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;

  // One classified access as it travels from the front to the back.
  typedef struct packed {
    logic              is_err;
    logic              is_write;
    logic [BlockW-1:0] blk;
  } item_t;

  // Sequencer states of the lookup engine.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_MOD,
    BK_REM,
    BK_VREAD,
    BK_DONE
  } bk_state_e;

  // One step of the victim LFSR.
  function automatic logic [LfsrW-1:0] lfsr_step(input logic [LfsrW-1:0] v);
    logic [LfsrW-1:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LfsrMask;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/block_buffer_cache_lookup.sv =====
// Top level of the block buffer cache lookup: front end, queue and lookup engine.
//
// Usage: each beat on the s_axis channel is one access (block number in tdata,
// read/write kind in tuser). Each access produces exactly one result beat on
// m_axis, in order. The block limit is written over the cfg channel, which is
// always ready; write it only while no access is in flight.
// Flow: an out-of-range access skips the lookup. A lookup reads the tag store
// one slot a cycle and stops at the first hit; a miss reads every slot. A miss
// with no free slot then reduces the LFSR modulo SLOTS with a reciprocal
// multiply and fetches the victim's tag. One access is worked on at a time;
// the front end and a two-entry queue keep taking beats meanwhile.
// Reset clears all valid and dirty marks, reloads the LFSR seed and sets the
// block limit to 1000; the tag store needs no clearing.
// When the receiver stalls, the finished result waits in the output register,
// the engine holds its next result, and the queue fills until s_axis_tready
// drops.
`timescale 1ns / 1ps
`default_nettype none

module block_buffer_cache_lookup #(
  parameter int unsigned SLOTS = bbc_pkg::Slots
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // Configuration: block limit.
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire [bbc_pkg::LimitW-1:0]     cfg_data_i,
  // Access stream.
  input  wire                           s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  wire [bbc_pkg::InDataW-1:0]    s_axis_tdata_i,   // [9:0] block_number, [15:10] zero
  input  wire [0:0]                     s_axis_tuser_i,   // [0] kind
  // Result stream.
  output logic                          m_axis_tvalid_o,
  input  wire                           m_axis_tready_i,
  // [6:0] slot, [7] hit, [8] fill_needed, [9] writeback_valid,
  // [19:10] writeback_block, [23:20] zero
  output logic [bbc_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic [0:0]                    m_axis_tuser_o    // [0] error
);

  logic           fr_valid, fr_ready;
  bbc_pkg::item_t fr_item;
  logic           bk_valid, bk_ready;
  bbc_pkg::item_t bk_item;

  bbc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i[0]),
    .item_valid_o    (fr_valid),
    .item_ready_i    (fr_ready),
    .item_o          (fr_item)
  );

  bbc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_item_o   (bk_item)
  );

  bbc_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (bk_valid),
    .item_ready_o    (bk_ready),
    .item_i          (bk_item),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o[0])
  );

endmodule

`default_nettype wire

// ===== hw/rtl/bbc_front.sv =====
// Front end: holds the block limit register and classifies incoming accesses.
`timescale 1ns / 1ps
`default_nettype none

module bbc_front (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // Configuration write channel.
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire [bbc_pkg::LimitW-1:0]     cfg_data_i,
  // Access stream.
  input  wire                           s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  wire [bbc_pkg::InDataW-1:0]    s_axis_tdata_i,
  input  wire                           s_axis_tuser_i,
  // Classified items toward the queue.
  output logic                          item_valid_o,
  input  wire                           item_ready_i,
  output bbc_pkg::item_t                item_o
);

  logic [bbc_pkg::LimitW-1:0] limit_q, limit_d;
  logic [bbc_pkg::BlockW-1:0] blk;

  // The limit register takes every write beat.
  assign cfg_ready_o = 1'b1;
  assign limit_d     = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= bbc_pkg::LimitReset;
    end else begin
      limit_q <= limit_d;
    end
  end

  // Block numbers at or above the limit are marked as errors.
  assign blk = s_axis_tdata_i[bbc_pkg::BlockW-1:0];

  always_comb begin
    item_o.is_err   = ({1'b0, blk} >= limit_q);
    item_o.is_write = s_axis_tuser_i;
    item_o.blk      = blk;
  end

  assign item_valid_o    = s_axis_tvalid_i;
  assign s_axis_tready_o = item_ready_i;

endmodule

`default_nettype wire

// ===== hw/rtl/bbc_queue.sv =====
// Short FIFO that decouples the front end from the lookup engine.
`timescale 1ns / 1ps
`default_nettype none

module bbc_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_valid_i,
  output logic            push_ready_o,
  input  bbc_pkg::item_t  push_item_i,
  output logic            pop_valid_o,
  input  wire             pop_ready_i,
  output bbc_pkg::item_t  pop_item_o
);

  localparam int unsigned Depth = bbc_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  bbc_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bbc_back.sv =====
// Lookup engine: scans the slot directory, picks a free slot or a victim, drives results.
`timescale 1ns / 1ps
`default_nettype none

module bbc_back #(
  parameter int unsigned SLOTS = bbc_pkg::Slots
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // Items from the queue.
  input  wire                             item_valid_i,
  output logic                            item_ready_o,
  input  bbc_pkg::item_t                  item_i,
  // Result stream.
  output logic                            m_axis_tvalid_o,
  input  wire                             m_axis_tready_i,
  output logic [bbc_pkg::OutDataW-1:0]    m_axis_tdata_o,
  output logic                            m_axis_tuser_o
);

  localparam int unsigned SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(SLOTS - 1);
  localparam int unsigned BlockW = bbc_pkg::BlockW;
  localparam int unsigned PadW   = bbc_pkg::OutDataW - bbc_pkg::SlotFieldW - 3 - BlockW;
  localparam int unsigned LfsrW  = bbc_pkg::LfsrW;
  localparam int unsigned ProdW  = 2 * LfsrW;
  // Reciprocal of SLOTS scaled by 2^LfsrW, rounded down.
  localparam logic [LfsrW-1:0] SlotsRecip = LfsrW'((2 ** LfsrW) / SLOTS);
  localparam logic [LfsrW-1:0] SlotsVal   = LfsrW'(SLOTS);

  bbc_pkg::bk_state_e          state_q, state_d;
  bbc_pkg::item_t              item_q, item_d;
  logic [SlotW-1:0]            rd_idx_q, rd_idx_d;
  logic                        issued_all_q, issued_all_d;
  logic                        cmp_v_q, cmp_v_d;
  logic                        cmp_vld_q, cmp_vld_d;
  logic [SlotW-1:0]            cmp_idx_q, cmp_idx_d;
  logic                        free_found_q, free_found_d;
  logic [SlotW-1:0]            free_idx_q, free_idx_d;
  logic                        hit_q, hit_d;
  logic                        evict_q, evict_d;
  logic [SlotW-1:0]            slot_q, slot_d;
  logic [LfsrW-1:0]            lfsr_q, lfsr_d;
  logic [LfsrW-1:0]            quot_q, quot_d;
  logic [SLOTS-1:0]            valid_vec_q, valid_vec_d;
  logic [SLOTS-1:0]            dirty_vec_q, dirty_vec_d;

  logic                        out_valid_q, out_valid_d;
  logic                        out_err_q, out_err_d;
  logic [SlotW-1:0]            out_slot_q, out_slot_d;
  logic                        out_hit_q, out_hit_d;
  logic                        out_fill_q, out_fill_d;
  logic                        out_wbv_q, out_wbv_d;
  logic [BlockW-1:0]           out_wbb_q, out_wbb_d;

  // Tag store and its registered read port.
  logic [BlockW-1:0]           tag_mem [SLOTS];
  logic [BlockW-1:0]           tag_q;
  logic                        rd_en;
  logic [SlotW-1:0]            rd_addr;
  logic                        mem_we;

  logic                        match;
  logic [ProdW-1:0]            quot_prod;
  logic [ProdW-1:0]            back_prod;
  logic [LfsrW-1:0]            rem_raw;
  logic [LfsrW-1:0]            rem_fix;
  logic                        wb_valid;

  assign match    = cmp_vld_q && (tag_q == item_q.blk);
  assign wb_valid = evict_q && dirty_vec_q[slot_q];

  // LFSR modulo SLOTS: the reciprocal estimate of the quotient is low by at most
  // one, so a single compare and subtract finishes the remainder.
  assign quot_prod = ProdW'(lfsr_q) * ProdW'(SlotsRecip);
  assign back_prod = ProdW'(quot_q) * ProdW'(SlotsVal);
  assign rem_raw   = lfsr_q - back_prod[LfsrW-1:0];
  assign rem_fix   = (rem_raw >= SlotsVal) ? rem_raw - SlotsVal : rem_raw;

  // Sequencer: next state, directory updates and result capture.
  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    rd_idx_d     = rd_idx_q;
    issued_all_d = issued_all_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    hit_d        = hit_q;
    evict_d      = evict_q;
    slot_d       = slot_q;
    lfsr_d       = lfsr_q;
    quot_d       = quot_q;
    valid_vec_d  = valid_vec_q;
    dirty_vec_d  = dirty_vec_q;
    out_err_d    = out_err_q;
    out_slot_d   = out_slot_q;
    out_hit_d    = out_hit_q;
    out_fill_d   = out_fill_q;
    out_wbv_d    = out_wbv_q;
    out_wbb_d    = out_wbb_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    item_ready_o = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = rd_idx_q;
    mem_we       = 1'b0;

    unique case (state_q)
      bbc_pkg::BK_IDLE: begin
        if (item_valid_i) begin
          item_ready_o = 1'b1;
          item_d       = item_i;
          hit_d        = 1'b0;
          evict_d      = 1'b0;
          slot_d       = '0;
          rd_idx_d     = '0;
          issued_all_d = 1'b0;
          free_found_d = 1'b0;
          state_d      = item_i.is_err ? bbc_pkg::BK_DONE : bbc_pkg::BK_SCAN;
        end
      end

      bbc_pkg::BK_SCAN: begin
        // Issue one tag read a cycle until the last slot is out.
        if (!issued_all_q) begin
          rd_en        = 1'b1;
          rd_idx_d     = rd_idx_q + SlotW'(1);
          issued_all_d = (rd_idx_q == LastSlot);
        end
        // Compare the tag read in the cycle before.
        if (cmp_v_q) begin
          if (match) begin
            hit_d   = 1'b1;
            slot_d  = cmp_idx_q;
            state_d = bbc_pkg::BK_DONE;
          end else begin
            if (!cmp_vld_q && !free_found_q) begin
              free_found_d = 1'b1;
              free_idx_d   = cmp_idx_q;
            end
            if (cmp_idx_q == LastSlot) begin
              if (free_found_q) begin
                slot_d  = free_idx_q;
                state_d = bbc_pkg::BK_DONE;
              end else if (!cmp_vld_q) begin
                slot_d  = cmp_idx_q;
                state_d = bbc_pkg::BK_DONE;
              end else begin
                // Directory full: advance the LFSR and reduce it modulo SLOTS.
                lfsr_d  = bbc_pkg::lfsr_step(lfsr_q);
                evict_d = 1'b1;
                state_d = bbc_pkg::BK_MOD;
              end
            end
          end
        end
      end

      bbc_pkg::BK_MOD: begin
        // Quotient estimate of the new LFSR value.
        quot_d  = quot_prod[ProdW-1:LfsrW];
        state_d = bbc_pkg::BK_REM;
      end

      bbc_pkg::BK_REM: begin
        // Corrected remainder names the victim slot.
        slot_d  = rem_fix[SlotW-1:0];
        state_d = bbc_pkg::BK_VREAD;
      end

      bbc_pkg::BK_VREAD: begin
        // Fetch the victim's tag for a possible write-back.
        rd_en   = 1'b1;
        rd_addr = slot_q;
        state_d = bbc_pkg::BK_DONE;
      end

      bbc_pkg::BK_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_err_d   = item_q.is_err;
          out_slot_d  = slot_q;
          out_hit_d   = hit_q;
          out_fill_d  = !item_q.is_err && !hit_q;
          out_wbv_d   = wb_valid;
          out_wbb_d   = wb_valid ? tag_q : '0;
          if (!item_q.is_err) begin
            if (hit_q) begin
              if (item_q.is_write) begin
                dirty_vec_d[slot_q] = 1'b1;
              end
            end else begin
              valid_vec_d[slot_q] = 1'b1;
              dirty_vec_d[slot_q] = item_q.is_write;
              mem_we              = 1'b1;
            end
          end
          state_d = bbc_pkg::BK_IDLE;
        end
      end

      default: begin
        state_d = bbc_pkg::BK_IDLE;
      end
    endcase

    cmp_v_d   = rd_en && (state_q == bbc_pkg::BK_SCAN);
    cmp_vld_d = valid_vec_q[rd_idx_q];
    cmp_idx_d = rd_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bbc_pkg::BK_IDLE;
      rd_idx_q     <= '0;
      issued_all_q <= 1'b0;
      cmp_v_q      <= 1'b0;
      free_found_q <= 1'b0;
      lfsr_q       <= bbc_pkg::LfsrSeed;
      valid_vec_q  <= '0;
      dirty_vec_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_idx_q     <= rd_idx_d;
      issued_all_q <= issued_all_d;
      cmp_v_q      <= cmp_v_d;
      free_found_q <= free_found_d;
      lfsr_q       <= lfsr_d;
      valid_vec_q  <= valid_vec_d;
      dirty_vec_q  <= dirty_vec_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    cmp_vld_q  <= cmp_vld_d;
    cmp_idx_q  <= cmp_idx_d;
    free_idx_q <= free_idx_d;
    hit_q      <= hit_d;
    evict_q    <= evict_d;
    slot_q     <= slot_d;
    quot_q     <= quot_d;
    out_err_q  <= out_err_d;
    out_slot_q <= out_slot_d;
    out_hit_q  <= out_hit_d;
    out_fill_q <= out_fill_d;
    out_wbv_q  <= out_wbv_d;
    out_wbb_q  <= out_wbb_d;
  end

  // Tag store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[slot_q] <= item_q.blk;
    end
    if (rd_en) begin
      tag_q <= tag_mem[rd_addr];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_err_q;
  assign m_axis_tdata_o  = {{PadW{1'b0}}, out_wbb_q, out_wbv_q, out_fill_q, out_hit_q,
                            bbc_pkg::SlotFieldW'(out_slot_q)};

endmodule

`default_nettype wire

// ===== hw/rtl/bbc_checker.sv =====
// Port-level checker for the block buffer cache lookup, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bbc_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          m_axis_tvalid_i,
  input wire                          m_axis_tready_i,
  input wire [bbc_pkg::OutDataW-1:0]  m_axis_tdata_i,
  input wire [0:0]                    m_axis_tuser_i
);

  logic       err, hit, fill, wbv;
  logic [9:0] wbb;

  assign err  = m_axis_tuser_i[0];
  assign hit  = m_axis_tdata_i[7];
  assign fill = m_axis_tdata_i[8];
  assign wbv  = m_axis_tdata_i[9];
  assign wbb  = m_axis_tdata_i[19:10];

  // A rejected access carries no slot information.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && err |-> m_axis_tdata_i == '0)
    else $error("error beat with nonzero payload");

  // A valid access either hits or needs a fill, never both.
  a_hit_xor_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !err |-> $onehot({hit, fill}))
    else $error("hit and fill_needed inconsistent");

  // A write-back only comes with a fill, and its block is zero otherwise.
  a_wb_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && (wbv ? !fill : wbb != '0) |-> 1'b0)
    else $error("write-back fields inconsistent");

  // A stalled result beat holds its payload.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i))
    else $error("result beat changed while stalled");

endmodule

bind block_buffer_cache_lookup bbc_checker u_bbc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);

`default_nettype wire
